// File: rtl/nps_pkg.sv
package nps_pkg;

    // Controller to datapath
    typedef struct packed {
        logic load_start;   // take a start value as the first candidate
        logic cand_inc;     // step to the next candidate, divisor back to two
        logic div_start;    // begin a division of the candidate by the divisor
        logic div_next;     // advance the divisor and begin a new division
        logic div_step;     // one restoring division step
        logic load_out;     // capture the result into the output register
        logic out_found;    // result is a prime (else no-prime flag)
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cand_lt2;     // candidate is zero or one
        logic cand_is_max;  // candidate is the largest value of the width
        logic div_last;     // current division step is the final one
        logic quo_lt_div;   // quotient below divisor: no divisor left to try
        logic rem_zero;     // divisor divides the candidate
    } t_dp_status;

    localparam int unsigned OutWidth = 32;

endpackage

// File: rtl/next_prime_search_unit.sv
// Finds the smallest prime at or above the start value by trial division,
// one item at a time. The start value is reduced to VALUE_WIDTH bits; when no
// prime lies between it and the largest VALUE_WIDTH-bit value, the result
// carries zero and the no-prime flag. Each divisor is tried in the shared
// bit-serial restoring divider (one quotient bit a cycle, then the quotient
// and remainder are judged), and divisors run from 2 while divisor <=
// candidate / divisor. Each candidate is checked, then divided by each
// divisor in turn, including the final division whose quotient falls below
// the divisor. An item is accepted in the idle state and ends in a done state
// that loads the output register, which waits while the previous result has
// not been taken. A new start value is taken while the previous result still
// waits in the output register.
module next_prime_search_unit #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_start_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_prime_found,
    output logic        o_no_prime
);

    nps_pkg::t_dp_cmd    cmd;
    nps_pkg::t_dp_status status;

    nps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    nps_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_start_value (i_start_value),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_prime_found (o_prime_found),
        .o_no_prime    (o_no_prime)
    );

endmodule

// File: rtl/nps_ctrl.sv
module nps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  nps_pkg::t_dp_status i_status,
    output nps_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_EVAL,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_found, n_found;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.out_found = r_found;

        // drop the result once the beat is taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_start = 1'b1;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.cand_lt2) begin
                    if (i_status.cand_is_max) begin
                        n_found = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.cand_inc = 1'b1;
                    end
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_status.quo_lt_div) begin
                    n_found = 1'b1;
                    n_state = ST_DONE;
                end else if (i_status.rem_zero) begin
                    // composite: move on, or give up at the top of the range
                    if (i_status.cand_is_max) begin
                        n_found = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.cand_inc = 1'b1;
                        n_state = ST_CHECK;
                    end
                end else begin
                    o_cmd.div_next = 1'b1;
                    n_state = ST_DIVIDE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

// File: rtl/nps_datapath.sv
module nps_datapath #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic [31:0]         i_start_value,
    input  nps_pkg::t_dp_cmd    i_cmd,
    output nps_pkg::t_dp_status o_status,
    output logic [31:0]         o_prime_found,
    output logic                o_no_prime
);

    localparam int unsigned CntWidth = $clog2(VALUE_WIDTH);
    localparam int unsigned OutW     = nps_pkg::OutWidth;

    logic [VALUE_WIDTH-1:0] r_cand;
    logic [VALUE_WIDTH-1:0] r_div;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [CntWidth-1:0]    r_cnt;
    logic [OutW-1:0]        r_prime_found;
    logic                   r_no_prime;

    logic [VALUE_WIDTH+OutW-1:0] start_ext;
    logic [VALUE_WIDTH+OutW-1:0] cand_ext;
    logic [VALUE_WIDTH:0]        rem_sh;
    logic [VALUE_WIDTH:0]        rem_diff;
    logic                        rem_ge;

    // reduce or widen the start value to the working width
    assign start_ext = {{VALUE_WIDTH{1'b0}}, i_start_value};
    assign cand_ext  = {{OutW{1'b0}}, r_cand};

    assign rem_sh   = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_div});
    assign rem_diff = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_cand <= start_ext[VALUE_WIDTH-1:0];
            r_div  <= VALUE_WIDTH'(2);
        end else if (i_cmd.cand_inc) begin
            r_cand <= r_cand + VALUE_WIDTH'(1);
            r_div  <= VALUE_WIDTH'(2);
        end else if (i_cmd.div_next) begin
            r_div  <= r_div + VALUE_WIDTH'(1);
        end

        if (i_cmd.div_start || i_cmd.div_next) begin
            r_quo <= r_cand;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[VALUE_WIDTH-2:0], rem_ge};
            r_rem <= rem_ge ? rem_diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
            r_cnt <= r_cnt + CntWidth'(1);
        end

        if (i_cmd.load_out) begin
            r_prime_found <= i_cmd.out_found ? cand_ext[OutW-1:0] : '0;
            r_no_prime    <= ~i_cmd.out_found;
        end
    end

    assign o_status.cand_lt2    = (r_cand < VALUE_WIDTH'(2));
    assign o_status.cand_is_max = &r_cand;
    assign o_status.div_last    = (r_cnt == CntWidth'(VALUE_WIDTH - 1));
    assign o_status.quo_lt_div  = (r_quo < r_div);
    assign o_status.rem_zero    = (r_rem == '0);

    assign o_prime_found = r_prime_found;
    assign o_no_prime    = r_no_prime;

endmodule

// File: tb/sv/tb_next_prime_search_unit.sv
module tb_next_prime_search_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] ValueMax = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] prime_found;
        logic        no_prime;
    } t_prime_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_start_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_prime_found;
    logic        o_no_prime;

    t_prime_result pending_primes[$];
    int unsigned   fail_count = 0;
    bit            tx_gaps_on = 1'b1;
    bit            rx_stalls_on = 1'b1;
    int unsigned   rx_stall_left = 0;

    next_prime_search_unit #(
        .VALUE_WIDTH(32)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_start_value (i_start_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_prime_found (o_prime_found),
        .o_no_prime    (o_no_prime)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("next_prime_search_unit regression: fail");
        $finish;
    end

    function automatic bit is_prime_u32(input logic [31:0] n);
        longint unsigned value;
        value = n;
        if (value < 2) begin
            return 1'b0;
        end
        for (longint unsigned d = 2; d <= value / d; d++) begin
            if (value % d == 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Walk upward from the start value; give up past the 32-bit maximum.
    function automatic t_prime_result smallest_prime_from(input logic [31:0] start);
        t_prime_result   res;
        longint unsigned cand;
        cand = start;
        res.prime_found = '0;
        res.no_prime = 1'b1;
        forever begin
            if (is_prime_u32(cand[31:0])) begin
                res.prime_found = cand[31:0];
                res.no_prime = 1'b0;
                return res;
            end
            if (cand >= ValueMax) begin
                return res;
            end
            cand++;
        end
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(20, 200);
        end
        return $urandom_range(0, 3);
    endfunction

    // Keep most values small so the trial division stays short.
    function automatic logic [31:0] pick_start();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return $urandom_range(0, 1023);
        end else if (r < 90) begin
            return $urandom_range(1024, 8191);
        end else if (r < 97) begin
            return $urandom_range(8192, 65535);
        end
        return ValueMax - $urandom_range(0, 1);
    endfunction

    task automatic send_start(input logic [31:0] value);
        int unsigned gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_start_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_primes.push_back(smallest_prime_from(value));
    endtask

    // Receive side: random stalls on i_ready, check every beat taken.
    always @(posedge i_clk) begin
        t_prime_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_primes.size() == 0) begin
                $display("%0t: unexpected result prime_found %0d no_prime %0b",
                         $time, o_prime_found, o_no_prime);
                fail_count++;
            end else begin
                want = pending_primes.pop_front();
                if (o_prime_found !== want.prime_found) begin
                    $display("%0t: prime_found expected %0d actual %0d",
                             $time, want.prime_found, o_prime_found);
                    fail_count++;
                end
                if (o_no_prime !== want.no_prime) begin
                    $display("%0t: no_prime expected %0b actual %0b",
                             $time, want.no_prime, o_no_prime);
                    fail_count++;
                end
            end
        end
        if (rx_stall_left > 0) begin
            i_ready <= 1'b0;
            rx_stall_left--;
        end else begin
            i_ready <= 1'b1;
            if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
                rx_stall_left = pick_gap();
            end
        end
    end

    task automatic test_field_extremes();
        send_start(32'd0);
        send_start(32'd1);
        send_start(32'd2);
        send_start(32'd3);
        send_start(32'd4);
        send_start(32'd65521);
        send_start(32'd65536);
        send_start(ValueMax);
    endtask

    // Squares of primes sit right at the divisor limit; 1021 and 1024 follow.
    task automatic test_square_boundaries();
        send_start(32'd25);
        send_start(32'd49);
        send_start(32'd121);
        send_start(32'd169);
        send_start(32'd1021);
        send_start(32'd1024);
    endtask

    // Composite runs between primes.
    task automatic test_prime_gaps();
        send_start(32'd24);
        send_start(32'd90);
        send_start(32'd114);
        send_start(32'd888);
    endtask

    // Nothing prime above the last 32-bit prime; one hard composite in there.
    task automatic test_no_prime_tail();
        send_start(ValueMax - 32'd2);
        send_start(ValueMax - 32'd1);
        send_start(ValueMax);
    endtask

    task automatic test_back_to_back();
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (20) send_start($urandom_range(0, 511));
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    task automatic test_random_starts();
        repeat (60) send_start(pick_start());
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_square_boundaries();
        test_prime_gaps();
        test_no_prime_tail();
        test_back_to_back();
        test_random_starts();

        @(posedge i_clk);
        i_valid <= 1'b0;
        while (pending_primes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("next_prime_search_unit regression: pass");
        end else begin
            $display("next_prime_search_unit regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/nps_pkg.sv
rtl/nps_ctrl.sv
rtl/nps_datapath.sv
rtl/next_prime_search_unit.sv
tb/sv/tb_next_prime_search_unit.sv
